### src/hg_pkg.sv
// Shared types, constants and helper functions for the histogram engine.
// No dependencies; every other file of the block imports this package.
package hg_pkg;

    localparam int MAX_BINS_DEF    = 64;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int BIN_W           = 6;
    localparam int NB_W            = 7;
    localparam int SCALE_W         = 24;
    localparam int PROM_W          = 9;
    localparam int MAX_RESULTS     = 32;
    localparam int K_W             = 6;
    localparam int QUEUE_DEPTH     = 2;
    localparam int PADDR_W         = 5;
    localparam int PDATA_W         = 32;

    localparam logic [PROM_W-1:0] PROM_ONE = 9'd256;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_PEAKS = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        REG_RANGE_LOW   = 3'd0,
        REG_RANGE_HIGH  = 3'd1,
        REG_BIN_SCALE   = 3'd2,
        REG_BINS_IN_USE = 3'd3,
        REG_PROMINENCE  = 3'd4
    } reg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_UPD,
        S_RD_DATA,
        S_EMIT,
        S_SC_RD,
        S_SC_SH,
        S_SC_MUL,
        S_SC_CMP,
        S_SC_END
    } back_state_t;

    typedef struct packed {
        opcode_t            opcode;
        logic signed [15:0] sample;
        logic [BIN_W-1:0]   bin_select;
    } item_t;

    typedef struct packed {
        logic             accepted;
        logic [BIN_W-1:0] bin_index;
        logic [31:0]      bin_count;
        logic [31:0]      total_count;
        logic [31:0]      max_count;
        logic [BIN_W-1:0] max_index;
        logic             range_error;
        logic             peak_found;
        logic             last;
    } result_t;

    typedef struct packed {
        logic signed [15:0] range_low;
        logic signed [15:0] range_high;
        logic [SCALE_W-1:0] bin_scale;
        logic [NB_W-1:0]    bins_in_use;
        logic [PROM_W-1:0]  prominence;
    } cfg_t;

    typedef struct packed {
        opcode_t          op;
        logic             in_range;
        logic [BIN_W-1:0] bin;
    } cmd_t;

    typedef struct packed {
        logic             accepted;
        logic [BIN_W-1:0] bin_index;
        logic [31:0]      bin_count;
        logic             range_error;
        logic             peak_found;
        logic             last;
    } res_t;

    function automatic logic [NB_W-1:0] active_bins(logic [NB_W-1:0] b, int max_bins);
        logic [NB_W-1:0] n;
        n = b;
        if (n == '0) n = NB_W'(1);
        if (n > NB_W'(max_bins)) n = NB_W'(max_bins);
        return n;
    endfunction

endpackage

### src/hg_front.sv
// Front end of the histogram engine: accepts transactions and classifies them.
// Computes the target bin of a sample. Depends on hg_pkg.
module hg_front #(
    parameter int MAX_BINS = hg_pkg::MAX_BINS_DEF
) (
    input  hg_pkg::cfg_t  cfg,
    input  logic          item_valid,
    output logic          item_stall,
    input  hg_pkg::item_t item_data,
    input  logic          full,
    output logic          push,
    output hg_pkg::cmd_t  push_cmd
);
    import hg_pkg::*;

    logic [NB_W-1:0]  n;
    logic [NB_W-1:0]  last_bin;
    logic             below;
    logic             above;
    logic             at_high;
    logic [16:0]      diff_s;
    logic [15:0]      diff;
    logic [39:0]      prod;
    logic [23:0]      q;
    logic [BIN_W-1:0] idx;

    always_comb
    begin
        n        = active_bins(cfg.bins_in_use, MAX_BINS);
        last_bin = n - NB_W'(1);
        below    = $signed(item_data.sample) < $signed(cfg.range_low);
        above    = $signed(item_data.sample) > $signed(cfg.range_high);
        at_high  = item_data.sample == cfg.range_high;
        diff_s   = {item_data.sample[15], item_data.sample} - {cfg.range_low[15], cfg.range_low};
        diff     = diff_s[15:0];
        prod     = 40'(diff) * 40'(cfg.bin_scale);
        q        = prod[39:16];
        if (at_high || (q > 24'(last_bin)))
        begin
            idx = last_bin[BIN_W-1:0];
        end
        else
        begin
            idx = q[BIN_W-1:0];
        end
        push_cmd.op       = item_data.opcode;
        push_cmd.in_range = !below && !above;
        push_cmd.bin      = (item_data.opcode == OP_READ) ? item_data.bin_select : idx;
    end

    assign item_stall = full;
    assign push       = item_valid && !full;

endmodule

### src/hg_fifo.sv
// Short command queue between the front end and the back end.
// Depends on hg_pkg for the command type and its depth.
module hg_fifo (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  hg_pkg::cmd_t push_cmd,
    output logic         full,
    input  logic         pop,
    output hg_pkg::cmd_t pop_cmd,
    output logic         not_empty
);
    import hg_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    cmd_t          entries_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + (PW+1)'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - (PW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign full      = cnt_reg == (PW+1)'(QUEUE_DEPTH);
    assign not_empty = cnt_reg != '0;
    assign pop_cmd   = entries_reg[rd_ptr_reg];

endmodule

### src/hg_back.sv
// Back end of the histogram engine: bin store, total, running maximum,
// peak scan sequencer and the result register. Depends on hg_pkg.
module hg_back #(
    parameter int MAX_BINS    = hg_pkg::MAX_BINS_DEF,
    parameter int COUNT_WIDTH = hg_pkg::COUNT_WIDTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  hg_pkg::cfg_t    cfg,
    input  logic            cmd_valid,
    input  hg_pkg::cmd_t    cmd,
    output logic            cmd_pop,
    output logic            result_valid,
    input  logic            result_stall,
    output hg_pkg::result_t result_data
);
    import hg_pkg::*;

    localparam int AW = $clog2(MAX_BINS);
    localparam int CW = COUNT_WIDTH;

    logic [CW-1:0]       mem [MAX_BINS];
    logic [MAX_BINS-1:0] vld_reg, vld_next;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [CW-1:0]       rd_data_reg;
    logic                rd_vld_reg;
    logic [CW-1:0]       rd_count;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [CW-1:0]       wr_data;

    back_state_t         state_reg, state_next;
    logic [CW-1:0]       total_reg, total_next;
    logic [CW-1:0]       lmax_reg, lmax_next;
    logic [BIN_W-1:0]    lidx_reg, lidx_next;
    res_t                res_reg, res_next;
    res_t                pend_reg, pend_next;
    logic                have_pend_reg, have_pend_next;
    logic [NB_W-1:0]     j_reg, j_next;
    logic [K_W-1:0]      k_reg, k_next;
    logic [CW-1:0]       w0_reg, w0_next;
    logic [CW-1:0]       w1_reg, w1_next;
    logic [CW-1:0]       w2_reg, w2_next;
    logic [CW:0]         thr_reg, thr_next;
    logic [CW+1:0]       t3_reg, t3_next;
    logic [CW+4:0]       p20_reg, p20_next;
    logic [CW+4:0]       p11_reg, p11_next;
    logic [CW+7:0]       pn_reg, pn_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_data_reg, out_data_next;

    logic [NB_W-1:0]     n;
    logic                out_free;
    logic                emit_en;
    res_t                emit_res;
    res_t                res_zero;
    res_t                cand;
    logic [CW-1:0]       c_inc;
    logic [PROM_W-1:0]   pclamp;
    logic [CW+8:0]       thr_prod;
    logic [CW:0]         nb_sum;
    logic                is_peak;
    logic                done_scan;

    function automatic logic [31:0] low32(logic [CW-1:0] x);
        logic [CW+31:0] w;
        w = {32'b0, x};
        return w[31:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_vld_reg  <= vld_reg[rd_addr];
        end
    end

    assign rd_count = rd_vld_reg ? rd_data_reg : '0;
    assign n        = active_bins(cfg.bins_in_use, MAX_BINS);
    assign out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        lmax_next      = lmax_reg;
        lidx_next      = lidx_reg;
        res_next       = res_reg;
        pend_next      = pend_reg;
        have_pend_next = have_pend_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        w0_next        = w0_reg;
        w1_next        = w1_reg;
        w2_next        = w2_reg;
        thr_next       = thr_reg;
        t3_next        = t3_reg;
        p20_next       = p20_reg;
        p11_next       = p11_reg;
        pn_next        = pn_reg;
        vld_next       = vld_reg;
        cmd_pop        = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = cmd.bin[AW-1:0];
        wr_en          = 1'b0;
        wr_addr        = res_reg.bin_index[AW-1:0];
        wr_data        = '0;
        emit_en        = 1'b0;
        emit_res       = res_reg;

        res_zero       = '0;
        res_zero.last  = 1'b1;

        c_inc    = (&rd_count) ? rd_count : rd_count + CW'(1);
        pclamp   = (cfg.prominence > PROM_ONE) ? PROM_ONE : cfg.prominence;
        thr_prod = (CW+9)'(lmax_reg) * (CW+9)'(pclamp);
        nb_sum   = {1'b0, w0_reg} + {1'b0, w2_reg};

        is_peak = (w1_reg > w0_reg) && (w1_reg > w2_reg)
            && ({1'b0, w1_reg} >= thr_reg)
            && (p20_reg > p11_reg)
            && (pn_reg > (CW+8)'(t3_reg));
        done_scan = j_reg == (n - NB_W'(1));

        cand             = '0;
        cand.bin_index   = BIN_W'(j_reg - NB_W'(1));
        cand.bin_count   = low32(w1_reg);
        cand.peak_found  = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        OP_ADD:
                        begin
                            if (cmd.in_range)
                            begin
                                res_next           = res_zero;
                                res_next.accepted  = 1'b1;
                                res_next.bin_index = cmd.bin;
                                rd_en              = 1'b1;
                                rd_addr            = cmd.bin[AW-1:0];
                                state_next         = S_ADD_UPD;
                            end
                            else
                            begin
                                res_next   = res_zero;
                                state_next = S_EMIT;
                            end
                        end
                        OP_CLEAR:
                        begin
                            vld_next   = '0;
                            total_next = '0;
                            lmax_next  = '0;
                            lidx_next  = '0;
                            res_next   = res_zero;
                            state_next = S_EMIT;
                        end
                        OP_READ:
                        begin
                            res_next           = res_zero;
                            res_next.bin_index = cmd.bin;
                            if ({1'b0, cmd.bin} >= n)
                            begin
                                res_next.range_error = 1'b1;
                                state_next           = S_EMIT;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = cmd.bin[AW-1:0];
                                state_next = S_RD_DATA;
                            end
                        end
                        OP_PEAKS:
                        begin
                            if (n < NB_W'(3))
                            begin
                                res_next   = res_zero;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                thr_next       = thr_prod[CW+8:8];
                                t3_next        = (CW+2)'(total_reg) * (CW+2)'(2'd3);
                                j_next         = '0;
                                k_next         = '0;
                                have_pend_next = 1'b0;
                                state_next     = S_SC_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD_UPD:
            begin
                wr_en             = 1'b1;
                wr_addr           = res_reg.bin_index[AW-1:0];
                wr_data           = c_inc;
                vld_next[wr_addr] = 1'b1;
                total_next        = (&total_reg) ? total_reg : total_reg + CW'(1);
                if ((c_inc > lmax_reg) || ((c_inc == lmax_reg) && (res_reg.bin_index < lidx_reg)))
                begin
                    lmax_next = c_inc;
                    lidx_next = res_reg.bin_index;
                end
                res_next.bin_count = low32(c_inc);
                state_next         = S_EMIT;
            end
            S_RD_DATA:
            begin
                res_next.bin_count = low32(rd_count);
                state_next         = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    emit_en    = 1'b1;
                    emit_res   = res_reg;
                    state_next = S_IDLE;
                end
            end
            S_SC_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = j_reg[AW-1:0];
                state_next = S_SC_SH;
            end
            S_SC_SH:
            begin
                w0_next = w1_reg;
                w1_next = w2_reg;
                w2_next = rd_count;
                if (j_reg >= NB_W'(2))
                begin
                    state_next = S_SC_MUL;
                end
                else
                begin
                    j_next     = j_reg + NB_W'(1);
                    state_next = S_SC_RD;
                end
            end
            S_SC_MUL:
            begin
                p20_next   = (CW+5)'(w1_reg) * (CW+5)'(5'd20);
                p11_next   = (CW+5)'(nb_sum) * (CW+5)'(4'd11);
                pn_next    = (CW+8)'(w1_reg) * (CW+8)'({n, 1'b0});
                state_next = S_SC_CMP;
            end
            S_SC_CMP:
            begin
                if (is_peak)
                begin
                    if (!(have_pend_reg && !out_free))
                    begin
                        if (have_pend_reg)
                        begin
                            emit_en  = 1'b1;
                            emit_res = pend_reg;
                        end
                        pend_next      = cand;
                        have_pend_next = 1'b1;
                        k_next         = k_reg + K_W'(1);
                        if ((k_reg + K_W'(1) == K_W'(MAX_RESULTS)) || done_scan)
                        begin
                            state_next = S_SC_END;
                        end
                        else
                        begin
                            j_next     = j_reg + NB_W'(1);
                            state_next = S_SC_RD;
                        end
                    end
                end
                else if (done_scan)
                begin
                    state_next = S_SC_END;
                end
                else
                begin
                    j_next     = j_reg + NB_W'(1);
                    state_next = S_SC_RD;
                end
            end
            S_SC_END:
            begin
                if (have_pend_reg)
                begin
                    res_next      = pend_reg;
                    res_next.last = 1'b1;
                end
                else
                begin
                    res_next = res_zero;
                end
                state_next = S_EMIT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (emit_en)
        begin
            out_valid_next            = 1'b1;
            out_data_next.accepted    = emit_res.accepted;
            out_data_next.bin_index   = emit_res.bin_index;
            out_data_next.bin_count   = emit_res.bin_count;
            out_data_next.total_count = low32(total_reg);
            out_data_next.max_count   = low32(lmax_reg);
            out_data_next.max_index   = lidx_reg;
            out_data_next.range_error = emit_res.range_error;
            out_data_next.peak_found  = emit_res.peak_found;
            out_data_next.last        = emit_res.last;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vld_reg       <= '0;
            total_reg     <= '0;
            lmax_reg      <= '0;
            lidx_reg      <= '0;
            have_pend_reg <= 1'b0;
            j_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vld_reg       <= vld_next;
            total_reg     <= total_next;
            lmax_reg      <= lmax_next;
            lidx_reg      <= lidx_next;
            have_pend_reg <= have_pend_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg      <= res_next;
        pend_reg     <= pend_next;
        w0_reg       <= w0_next;
        w1_reg       <= w1_next;
        w2_reg       <= w2_next;
        thr_reg      <= thr_next;
        t3_reg       <= t3_next;
        p20_reg      <= p20_next;
        p11_reg      <= p11_next;
        pn_reg       <= pn_next;
        out_data_reg <= out_data_next;
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

    a_rerr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_data.range_error) |-> (result_data.bin_count == 32'd0))
        else $error("Range error transaction carries a nonzero bin count.");

    a_peak_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_data.peak_found)
            |-> (!result_data.accepted && !result_data.range_error))
        else $error("Peak transaction carries add or read flags.");

    a_peak_limit: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= K_W'(MAX_RESULTS))
        else $error("Peak count exceeds the result limit.");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && cmd_pop && cmd.op == OP_CLEAR)
            |=> (total_reg == '0 && lmax_reg == '0 && vld_reg == '0))
        else $error("Clear did not empty the histogram.");

endmodule

### src/histogram_binning_peak_finder_core.sv
// Histogram engine with peak detection, top level: APB registers, front, queue, back.
// Add sample and read bin read the bin first; clear and rejected or out-of-range ones do not.
// Find peaks reads, shifts, multiplies, compares per active bin; result stalls can hold it.
// The two-entry queue lets the front accept while the back end works or its result waits.
// Reset is asynchronous, active low: all bins read as zero, registers take their reset values.
// Depends on hg_pkg, hg_front, hg_fifo and hg_back.
module histogram_binning_peak_finder_core #(
    parameter int MAX_BINS    = hg_pkg::MAX_BINS_DEF,
    parameter int COUNT_WIDTH = hg_pkg::COUNT_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  hg_pkg::item_t                item_data,
    output logic                         result_valid,
    input  logic                         result_stall,
    output hg_pkg::result_t              result_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hg_pkg::PADDR_W-1:0]   paddr,
    input  logic [hg_pkg::PDATA_W-1:0]   pwdata,
    output logic [hg_pkg::PDATA_W-1:0]   prdata,
    output logic                         pready
);
    import hg_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    reg_index_t reg_sel;
    logic       wr_en;
    logic       push;
    cmd_t       push_cmd;
    logic       full;
    logic       pop;
    cmd_t       pop_cmd;
    logic       not_empty;

    assign pready  = 1'b1;
    assign reg_sel = reg_index_t'(paddr[PADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_RANGE_LOW:   cfg_next.range_low   = pwdata[15:0];
                REG_RANGE_HIGH:  cfg_next.range_high  = pwdata[15:0];
                REG_BIN_SCALE:   cfg_next.bin_scale   = pwdata[SCALE_W-1:0];
                REG_BINS_IN_USE: cfg_next.bins_in_use = pwdata[NB_W-1:0];
                REG_PROMINENCE:  cfg_next.prominence  = pwdata[PROM_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_RANGE_LOW:   prdata = PDATA_W'(cfg_reg.range_low);
            REG_RANGE_HIGH:  prdata = PDATA_W'(cfg_reg.range_high);
            REG_BIN_SCALE:   prdata = PDATA_W'(cfg_reg.bin_scale);
            REG_BINS_IN_USE: prdata = PDATA_W'(cfg_reg.bins_in_use);
            REG_PROMINENCE:  prdata = PDATA_W'(cfg_reg.prominence);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.range_low   <= 16'h8000;
            cfg_reg.range_high  <= 16'h7FFF;
            cfg_reg.bin_scale   <= 24'd65537;
            cfg_reg.bins_in_use <= 7'd64;
            cfg_reg.prominence  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    hg_front #(
        .MAX_BINS(MAX_BINS)
    ) u_front (
        .cfg       (cfg_reg),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item_data (item_data),
        .full      (full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    hg_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .not_empty(not_empty)
    );

    hg_back #(
        .MAX_BINS   (MAX_BINS),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .cmd_valid   (not_empty),
        .cmd         (pop_cmd),
        .cmd_pop     (pop),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_data (result_data)
    );

endmodule

### bench/testbench.sv
// Self-checking testbench for histogram_binning_peak_finder_core.
// Predicts every result from its own model of bins, total and maximum and checks each result.
// Depends on hg_pkg and the RTL of the block.
`timescale 1ns / 100ps

module testbench;
    import hg_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    item_t item_data = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    result_t result_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    histogram_binning_peak_finder_core dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item_data(item_data),
        .result_valid(result_valid), .result_stall(result_stall),
        .result_data(result_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    logic [31:0] bin_store [64];
    logic [31:0] sample_sum;
    logic [31:0] top_count;
    logic [5:0] top_bin;
    logic signed [15:0] cfg_low;
    logic signed [15:0] cfg_high;
    logic [23:0] cfg_scale;
    logic [6:0] cfg_bins;
    logic [8:0] cfg_prom;

    result_t expected_results[$];
    bit quiet = 1'b0;
    int mismatches = 0;
    int results_seen = 0;
    int peaks_seen = 0;
    int items_sent = 0;
    int stall_left = 0;

    function automatic int active_count();
        int n;
        n = cfg_bins;
        if (n < 1) n = 1;
        if (n > 64) n = 64;
        return n;
    endfunction

    function automatic bit peak_at(int i, int n);
        longint unsigned c, a, b, p, thr;
        c = bin_store[i];
        a = bin_store[i-1];
        b = bin_store[i+1];
        p = (cfg_prom > 256) ? 256 : cfg_prom;
        thr = (longint'(top_count) * p) >> 8;
        if (!(c > a && c > b)) return 1'b0;
        if (c < thr) return 1'b0;
        if (!(20 * c > 11 * (a + b))) return 1'b0;
        return (2 * c * n) > (3 * longint'(sample_sum));
    endfunction

    task automatic predict_results(item_t it);
        result_t r;
        int n, lo, hi, v, idx;
        longint q;
        int k;
        n = active_count();
        r = '0;
        r.last = 1'b1;
        case (it.opcode)
            OP_ADD:
            begin
                lo = cfg_low;
                hi = cfg_high;
                v = it.sample;
                if (v >= lo && v <= hi) begin
                    if (v == hi) idx = n - 1;
                    else begin
                        q = (longint'(v - lo) * cfg_scale) >> 16;
                        idx = (q > n - 1) ? n - 1 : int'(q);
                    end
                    if (bin_store[idx] != 32'hFFFF_FFFF) bin_store[idx]++;
                    if (sample_sum != 32'hFFFF_FFFF) sample_sum++;
                    if (bin_store[idx] > top_count ||
                        (bin_store[idx] == top_count && idx < top_bin)) begin
                        top_count = bin_store[idx];
                        top_bin = 6'(idx);
                    end
                    r.accepted = 1'b1;
                    r.bin_index = 6'(idx);
                    r.bin_count = bin_store[idx];
                end
            end
            OP_CLEAR:
            begin
                foreach (bin_store[j]) bin_store[j] = '0;
                sample_sum = '0;
                top_count = '0;
                top_bin = '0;
            end
            OP_READ:
            begin
                r.bin_index = it.bin_select;
                if (it.bin_select >= n) r.range_error = 1'b1;
                else r.bin_count = bin_store[it.bin_select];
            end
            default:
            begin
                k = 0;
                for (int i = 1; i + 1 < n && k < MAX_RESULTS; i++) begin
                    if (peak_at(i, n)) begin
                        r = '0;
                        r.bin_index = 6'(i);
                        r.bin_count = bin_store[i];
                        r.peak_found = 1'b1;
                        r.total_count = sample_sum;
                        r.max_count = top_count;
                        r.max_index = top_bin;
                        r.last = (k == MAX_RESULTS - 1);
                        expected_results = {expected_results, r};
                        k++;
                    end
                end
                if (k > 0) begin
                    expected_results[$].last = 1'b1;
                    return;
                end
                r = '0;
                r.last = 1'b1;
            end
        endcase
        r.total_count = sample_sum;
        r.max_count = top_count;
        r.max_index = top_bin;
        expected_results = {expected_results, r};
    endtask

    task automatic send_item(opcode_t op, logic [15:0] s, logic [5:0] sel);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item_data.opcode <= op;
        item_data.sample <= s;
        item_data.bin_select <= sel;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        predict_results(item_data);
        items_sent++;
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (expected_results.size() > 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic reg_write(reg_index_t idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(idx) << 2;
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_RANGE_LOW: cfg_low = val[15:0];
            REG_RANGE_HIGH: cfg_high = val[15:0];
            REG_BIN_SCALE: cfg_scale = val[23:0];
            REG_BINS_IN_USE: cfg_bins = val[6:0];
            default: cfg_prom = val[8:0];
        endcase
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (quiet) result_stall <= 1'b0;
        else if (stall_left > 0) begin
            stall_left--;
            result_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 13);
            result_stall <= 1'b1;
        end else result_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && result_valid && !result_stall) begin
            results_seen++;
            if (result_data.peak_found) peaks_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result transaction: %p", result_data);
            end else begin
                exp_r = expected_results.pop_front();
                if (result_data.accepted !== exp_r.accepted ||
                    result_data.bin_index !== exp_r.bin_index ||
                    result_data.bin_count !== exp_r.bin_count ||
                    result_data.total_count !== exp_r.total_count ||
                    result_data.max_count !== exp_r.max_count ||
                    result_data.max_index !== exp_r.max_index ||
                    result_data.range_error !== exp_r.range_error ||
                    result_data.peak_found !== exp_r.peak_found ||
                    result_data.last !== exp_r.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %p, got %p", exp_r, result_data);
                end
            end
        end
    end

    task automatic test_defaults();
        send_item(OP_READ, 16'h0, 6'd0);
        send_item(OP_READ, 16'hFFFF, 6'd63);
        send_item(OP_ADD, 16'h8000, 6'd0);
        send_item(OP_ADD, 16'h7FFF, 6'd0);
        send_item(OP_ADD, 16'h0000, 6'd0);
        send_item(OP_PEAKS, 16'h0, 6'd0);
        send_item(OP_READ, 16'h0, 6'd63);
        send_item(OP_CLEAR, 16'h0, 6'd0);
        send_item(OP_READ, 16'h0, 6'd63);
        drain();
    endtask

    task automatic test_register_extremes();
        reg_write(REG_BINS_IN_USE, 32'd0);
        send_item(OP_ADD, 16'd5, 6'd0);
        send_item(OP_READ, 16'd0, 6'd1);
        send_item(OP_PEAKS, 16'd0, 6'd0);
        drain();
        reg_write(REG_BINS_IN_USE, 32'd127);
        reg_write(REG_PROMINENCE, 32'd511);
        reg_write(REG_BIN_SCALE, 32'd0);
        send_item(OP_ADD, 16'd100, 6'd0);
        drain();
        reg_write(REG_BIN_SCALE, 32'hFF_FFFF);
        send_item(OP_ADD, 16'h8001, 6'd0);
        send_item(OP_PEAKS, 16'd0, 6'd0);
        drain();
        reg_write(REG_RANGE_LOW, 32'd100);
        reg_write(REG_RANGE_HIGH, 32'hFF9C);
        send_item(OP_ADD, 16'd0, 6'd0);
        send_item(OP_ADD, 16'd100, 6'd0);
        send_item(OP_ADD, 16'hFF9C, 6'd0);
        drain();
    endtask

    task automatic test_random_phase(int count);
        int n, lo, span, hot, d, sel;
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 64) : $urandom_range(3, 16);
        lo = $urandom_range(0, 3000) - 2000;
        span = $urandom_range(n, 4000);
        reg_write(REG_RANGE_LOW, lo);
        reg_write(REG_RANGE_HIGH, lo + span);
        reg_write(REG_BIN_SCALE, (n * 65536) / (span + 1));
        reg_write(REG_BINS_IN_USE, ($urandom_range(0, 7) == 0) ? $urandom_range(65, 127) : n);
        reg_write(REG_PROMINENCE, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                                              : $urandom_range(0, 200));
        if ($urandom_range(0, 2) == 0) send_item(OP_CLEAR, 16'($urandom), 6'($urandom));
        hot = $urandom_range(0, span);
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 19);
            if (sel < 13) begin
                if (sel < 7) d = hot + $urandom_range(0, span / n + 1);
                else if (sel < 12) d = $urandom_range(0, span);
                else d = $urandom_range(0, span + 40) - 20;
                if (sel == 0) hot = $urandom_range(0, span);
                send_item(OP_ADD, 16'(lo + d), 6'($urandom));
            end else if (sel < 14) send_item(OP_ADD, 16'($urandom), 6'($urandom));
            else if (sel < 17) send_item(OP_READ, 16'($urandom), 6'($urandom_range(0, 63)));
            else if (sel < 19) send_item(OP_PEAKS, 16'($urandom), 6'($urandom));
            else if ($urandom_range(0, 3) == 0) send_item(OP_CLEAR, 16'($urandom), 6'($urandom));
            else send_item(OP_PEAKS, 16'($urandom), 6'($urandom));
        end
        send_item(OP_PEAKS, 16'($urandom), 6'($urandom));
        drain();
    endtask

    task automatic test_stale_bins();
        reg_write(REG_BINS_IN_USE, 32'd4);
        reg_write(REG_PROMINENCE, 32'd256);
        send_item(OP_PEAKS, 16'd0, 6'd0);
        send_item(OP_READ, 16'd0, 6'd63);
        drain();
    endtask

    initial
    begin
        foreach (bin_store[j]) bin_store[j] = '0;
        sample_sum = '0;
        top_count = '0;
        top_bin = '0;
        cfg_low = 16'sh8000;
        cfg_high = 16'sh7FFF;
        cfg_scale = 24'd65537;
        cfg_bins = 7'd64;
        cfg_prom = 9'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults();
        test_register_extremes();
        for (int p = 0; p < 7; p++) test_random_phase(35);
        test_stale_bins();
        quiet = 1'b1;
        test_random_phase(35);
        $display("Sent %0d item transactions, checked %0d results, %0d of them peaks.",
                 items_sent, results_seen, peaks_seen);
        $display("Register settings covered empty and inverted ranges, extreme scales and sizes.");
        if (mismatches == 0 && expected_results.size() == 0)
            $display("[histogram_binning_peak_finder_core] OK");
        else
            $display("[histogram_binning_peak_finder_core] ERROR");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("[histogram_binning_peak_finder_core] ERROR");
        $finish;
    end
endmodule
